[design/pcmx_pkg.sv]
// Shared types and constants for the PCM channel mixer.
`default_nettype none

package pcmx_pkg;

   localparam int ADDR_W   = 16;
   localparam int LEN_W    = 17;
   localparam int VOL_W    = 7;
   localparam int STEP_W   = 16;
   localparam int LOOP_W   = 29;
   localparam int GAIN_SHIFT = 6;

   localparam logic [VOL_W-1:0] FULL_GAIN = 7'd64;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic KIND_MIX    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic start_claim;
      logic tick_begin;
      logic tick_run;
      logic push;
   } dp_cmd_type;

   typedef struct packed {
      logic run_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[design/pcmx_if.sv]
// Request and response channel interfaces of the PCM channel mixer.
`default_nettype none

interface pcmx_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [15:0]       address;
   logic signed [7:0] sample_byte;
   logic [16:0]       sound_length;
   logic [6:0]        volume;
   logic [15:0]       step;
   logic [28:0]       loop_span;

   modport source (output valid, opcode, address, sample_byte, sound_length, volume, step,
                   loop_span, input ready);
   modport sink (input valid, opcode, address, sample_byte, sound_length, volume, step,
                 loop_span, output ready);
endinterface

interface pcmx_rsp_if;
   logic              valid;
   logic              ready;
   logic              kind;
   logic signed [7:0] mixed_sample;
   logic              accepted;
   logic [1:0]        channel_index;

   modport source (output valid, kind, mixed_sample, accepted, channel_index, input ready);
   modport sink (input valid, kind, mixed_sample, accepted, channel_index, output ready);
endinterface

`default_nettype wire

[design/pcmx_ctrl.sv]
// Controller state machine of the PCM channel mixer.
`default_nettype none

module pcmx_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_opcode,
   input  wire pcmx_pkg::dp_status_type status,
   output pcmx_pkg::dp_cmd_type         cmd
);
   import pcmx_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_START: state_in = ST_PUSH;
                  OP_TICK:  state_in = ST_TICK;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            if (status.run_last) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_wr     = accept && (req_opcode == OP_LOAD);
            cmd.start_claim = accept && (req_opcode == OP_START);
            cmd.tick_begin  = accept && (req_opcode == OP_TICK);
         end
         ST_TICK: cmd.tick_run = 1'b1;
         ST_PUSH: cmd.push     = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

[design/pcmx_dp.sv]
// Datapath of the PCM channel mixer: sample memory, channel state, accumulator, output register.
`default_nettype none

module pcmx_dp #(
   parameter int CHANNELS         = 4,
   parameter int SAMPLE_MEM_DEPTH = 65536,
   parameter int FRAC_BITS        = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pcmx_pkg::dp_cmd_type cmd,
   output pcmx_pkg::dp_status_type   status,
   input  wire logic [15:0]          req_address,
   input  wire logic signed [7:0]    req_sample_byte,
   input  wire logic [16:0]          req_sound_length,
   input  wire logic [6:0]           req_volume,
   input  wire logic [15:0]          req_step,
   input  wire logic [28:0]          req_loop_span,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_kind,
   output logic signed [7:0]         rsp_mixed_sample,
   output logic                      rsp_accepted,
   output logic [1:0]                rsp_channel_index
);
   import pcmx_pkg::*;

   // The sample memory depth is a power of two, so address wrap is a truncation.
   localparam int LOG2_CH = $clog2(CHANNELS);
   localparam int CH_W    = (CHANNELS > 1) ? LOG2_CH : 1;
   localparam int CNT_W   = $clog2(CHANNELS + 1);
   localparam int AW      = $clog2(SAMPLE_MEM_DEPTH);
   localparam int POS_W   = LEN_W + FRAC_BITS;
   localparam int INT_W   = POS_W - FRAC_BITS;
   localparam int FA_W    = (AW > INT_W + 1) ? AW : INT_W + 1;
   localparam int LA_W    = (AW > ADDR_W) ? AW : ADDR_W;
   localparam int CMP_W   = (POS_W > LOOP_W) ? POS_W : LOOP_W;
   localparam int ACC_W   = 14 + LOG2_CH;
   localparam int SH      = GAIN_SHIFT + LOG2_CH;

   logic signed [7:0]  mem [SAMPLE_MEM_DEPTH];

   logic [CHANNELS-1:0] active_ff;
   logic [ADDR_W-1:0]   base_ff [CHANNELS];
   logic [POS_W-1:0]    pos_ff  [CHANNELS];
   logic [STEP_W-1:0]   step_ff [CHANNELS];
   logic [VOL_W-1:0]    gain_ff [CHANNELS];
   logic [POS_W-1:0]    end_ff  [CHANNELS];
   logic [POS_W-1:0]    loop_ff [CHANNELS];

   logic [CNT_W-1:0]    cnt_ff;
   logic                acc_en_ff;
   logic [VOL_W-1:0]    gain_sel_ff;
   logic signed [7:0]   rd_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic                stage_kind_ff;
   logic                stage_acc_ff;
   logic [1:0]          stage_idx_ff;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic signed [7:0]   rsp_mixed_ff;
   logic                rsp_acc_ff;
   logic [1:0]          rsp_idx_ff;

   logic                free_any;
   logic [CH_W-1:0]     free_idx;
   logic [POS_W-1:0]    end_val;
   logic [CMP_W-1:0]    loop_c;
   logic [CMP_W-1:0]    step_c;
   logic [CMP_W-1:0]    end_c;
   logic                start_ok;
   logic [VOL_W-1:0]    gain_val;

   logic [CH_W-1:0]     run_idx;
   logic                issue;
   logic [POS_W-1:0]    cur_pos;
   logic [POS_W-1:0]    adv_pos;
   logic [POS_W-1:0]    wrap_pos;
   logic                at_end;
   logic [FA_W-1:0]     fa;
   logic [LA_W-1:0]     la;
   logic signed [15:0]  prod;

   // Lowest free channel.
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_any = 1'b1;
            free_idx = CH_W'(i);
         end
      end
   end

   assign end_val  = POS_W'(req_sound_length) << FRAC_BITS;
   assign loop_c   = CMP_W'(req_loop_span);
   assign step_c   = CMP_W'(req_step);
   assign end_c    = CMP_W'(end_val);
   assign start_ok = free_any && ((req_loop_span == '0) || ((loop_c >= step_c) && (loop_c <= end_c)));
   assign gain_val = (req_volume > FULL_GAIN) ? FULL_GAIN : req_volume;

   assign run_idx  = cnt_ff[CH_W-1:0];
   assign issue    = cmd.tick_run && (cnt_ff < CNT_W'(CHANNELS));
   assign cur_pos  = pos_ff[run_idx];
   assign adv_pos  = cur_pos + POS_W'(step_ff[run_idx]);
   assign wrap_pos = adv_pos - loop_ff[run_idx];
   assign at_end   = (adv_pos >= end_ff[run_idx]);
   assign fa       = FA_W'(base_ff[run_idx]) + FA_W'(cur_pos[POS_W-1:FRAC_BITS]);
   assign la       = LA_W'(req_address);
   assign prod     = rd_ff * $signed({1'b0, gain_sel_ff});

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem[la[AW-1:0]] <= req_sample_byte;
      end
      if (issue) begin
         rd_ff <= mem[fa[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (cmd.start_claim && start_ok) begin
         active_ff[free_idx] <= 1'b1;
      end else if (issue && active_ff[run_idx] && at_end && (loop_ff[run_idx] == '0)) begin
         active_ff[run_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_claim && start_ok) begin
         base_ff[free_idx] <= req_address;
         pos_ff[free_idx]  <= '0;
         step_ff[free_idx] <= req_step;
         gain_ff[free_idx] <= gain_val;
         end_ff[free_idx]  <= end_val;
         loop_ff[free_idx] <= loop_c[POS_W-1:0];
      end else if (issue && active_ff[run_idx]) begin
         pos_ff[run_idx] <= (at_end && (loop_ff[run_idx] != '0)) ? wrap_pos : adv_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= issue && active_ff[run_idx];
         if (cmd.tick_begin) begin
            cnt_ff <= '0;
         end else if (cmd.tick_run) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Inactive channels never reach the accumulator, so unwritten memory cannot leak in.
   always_ff @(posedge clock) begin
      gain_sel_ff <= gain_ff[run_idx];
      if (cmd.tick_begin) begin
         acc_ff <= '0;
      end else if (acc_en_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_claim) begin
         stage_kind_ff <= KIND_STATUS;
         stage_acc_ff  <= start_ok;
         stage_idx_ff  <= start_ok ? 2'(free_idx) : 2'd0;
      end else if (cmd.tick_begin) begin
         stage_kind_ff <= KIND_MIX;
         stage_acc_ff  <= 1'b0;
         stage_idx_ff  <= 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The accumulator is wide enough that its top byte is the floor of the scaled sum.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_kind_ff  <= stage_kind_ff;
         rsp_mixed_ff <= (stage_kind_ff == KIND_MIX) ? $signed(acc_ff[ACC_W-1:SH]) : 8'sd0;
         rsp_acc_ff   <= stage_acc_ff;
         rsp_idx_ff   <= stage_idx_ff;
      end
   end

   assign status.run_last = (cnt_ff == CNT_W'(CHANNELS));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_mixed_sample  = rsp_mixed_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_channel_index = rsp_idx_ff;

endmodule

`default_nettype wire

[design/pcm_channel_mixer_top.sv]
// Top level of the PCM channel mixer.
//
// One request channel carries load, start and tick operations; one response
// channel returns a start status or a mixed sample. A load writes one byte
// into the local sample memory and gives no response. A start claims the
// lowest free channel and answers with accepted and the channel index. A tick
// mixes all active channels into one signed byte and advances them.
// A start stages its status, which is then moved into the output register; a
// tick walks over the channels and then moves the mixed sum there. The walk
// takes one channel per cycle through the single memory read port and
// multiply-accumulate unit. A load stays in the idle state. Requests are taken
// one at a time: the next request transfer can follow the cycle after the
// result is moved into the output register.
// The output register lets a new request in while a response waits; if the
// receiver stalls, the following start or tick holds until the register frees.
// Reset clears all channels and the output; the sample memory is not cleared
// and must be loaded before a channel plays it.
`default_nettype none

module pcm_channel_mixer_top #(
   parameter int CHANNELS         = 4,
   parameter int SAMPLE_MEM_DEPTH = 65536,
   parameter int FRAC_BITS        = 12
) (
   input wire logic  clock,
   input wire logic  reset,
   pcmx_req_if.sink  req_chan,
   pcmx_rsp_if.source rsp_chan
);
   import pcmx_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pcmx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_opcode (req_chan.opcode),
      .status     (status),
      .cmd        (cmd)
   );

   pcmx_dp #(
      .CHANNELS         (CHANNELS),
      .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH),
      .FRAC_BITS        (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_address       (req_chan.address),
      .req_sample_byte   (req_chan.sample_byte),
      .req_sound_length  (req_chan.sound_length),
      .req_volume        (req_chan.volume),
      .req_step          (req_chan.step),
      .req_loop_span     (req_chan.loop_span),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_kind          (rsp_chan.kind),
      .rsp_mixed_sample  (rsp_chan.mixed_sample),
      .rsp_accepted      (rsp_chan.accepted),
      .rsp_channel_index (rsp_chan.channel_index)
   );

endmodule

`default_nettype wire

[design/pcmx_checker.sv]
// Port-level assertions for the PCM channel mixer and their binding to the top level.
`default_nettype none

module pcmx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_opcode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_kind,
   input wire logic       rsp_accepted,
   input wire logic [1:0] rsp_channel_index
);
   import pcmx_pkg::*;

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A start or tick transfer keeps the block busy in the next cycle.
   a_busy_after_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && ((req_opcode == OP_START) || (req_opcode == OP_TICK))
      |=> !req_ready)
      else $error("request taken while a start or tick is in progress");

   a_reject_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_STATUS) && !rsp_accepted |-> rsp_channel_index == 2'd0)
      else $error("rejected start carries a channel index");

   a_mix_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_MIX) |-> !rsp_accepted && (rsp_channel_index == 2'd0))
      else $error("mixed sample carries start status fields");

endmodule

bind pcm_channel_mixer_top pcmx_checker u_pcmx_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_opcode        (req_chan.opcode),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_accepted      (rsp_chan.accepted),
   .rsp_channel_index (rsp_chan.channel_index)
);

`default_nettype wire
